// File: hdl/ssmbd_pkg.sv
// ----------------------------------------------------------------------------
// ssmbd_pkg
// Types, codes and digit rendering helpers for the seven-segment mux driver.
// ----------------------------------------------------------------------------
package ssmbd_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_FLASH = 2'd2,
    OP_HOLD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BLINK_NONE = 2'd0,
    BLINK_ALL  = 2'd1,
    BLINK_LOW  = 2'd2,
    BLINK_HIGH = 2'd3
  } blink_e;

  typedef enum logic [2:0] {
    CFG_BLINK_SELECT  = 3'd0,
    CFG_ZERO_SUPPRESS = 3'd1,
    CFG_BLINK_PERIOD  = 3'd2,
    CFG_BLANK_POINT   = 3'd3,
    CFG_COLON_TICKS   = 3'd4
  } cfg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumDigits = 4;

  localparam logic [15:0] BlinkPeriodRst = 16'd1000;
  localparam logic [15:0] BlankPointRst  = 16'd500;
  localparam logic [7:0]  ColonTicksRst  = 8'd100;

  localparam logic [3:0] BcdMinus  = 4'd10;
  localparam logic [7:0] SegBlank  = 8'h00;
  localparam logic [7:0] ColonBit  = 8'h80;
  localparam logic [8:0] ColonHold = 9'h100;

  typedef struct packed {
    op_e        operation;
    logic [6:0] high_value;
    logic [6:0] low_value;
    logic       minus_sign;
  } in_item_t;

  typedef struct packed {
    logic [1:0] digit_select;
    logic [7:0] segments;
  } out_item_t;

  function automatic logic [7:0] seg_of(logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      4'd10:   seg = 8'h40;
      4'd11:   seg = 8'h79;
      4'd12:   seg = 8'h76;
      4'd13:   seg = 8'h38;
      4'd14:   seg = 8'h73;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // top digit goes dark on a zero tens digit when suppression is on
  function automatic logic [7:0] digit_glyph(logic [3:0] code, logic top, logic zs);
    logic [7:0] seg;
    if (top && zs && (code == 4'd0)) begin
      seg = SegBlank;
    end else begin
      seg = seg_of(code);
    end
    return seg;
  endfunction

  // shift-and-add-3 on a value saturated to 99, tens in [7:4], units in [3:0]
  function automatic logic [7:0] to_bcd(logic [6:0] v);
    logic [6:0] sat;
    logic [7:0] bcd;
    sat = (v > 7'd99) ? 7'd99 : v;
    bcd = 8'd0;
    for (int i = 6; i >= 0; i--) begin
      if (bcd[3:0] >= 4'd5) bcd[3:0] = bcd[3:0] + 4'd3;
      if (bcd[7:4] >= 4'd5) bcd[7:4] = bcd[7:4] + 4'd3;
      bcd = {bcd[6:0], sat[i]};
    end
    return bcd;
  endfunction

  function automatic logic [3:0] group_mask(blink_e sel);
    logic [3:0] m;
    case (sel)
      BLINK_ALL:  m = 4'b1111;
      BLINK_LOW:  m = 4'b0011;
      BLINK_HIGH: m = 4'b1100;
      default:    m = 4'b0000;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] flag_mask(blink_e sel);
    logic [2:0] m;
    case (sel)
      BLINK_ALL:  m = 3'b001;
      BLINK_LOW:  m = 3'b010;
      BLINK_HIGH: m = 3'b100;
      default:    m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

// File: hdl/seven_segment_mux_blink_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_mux_blink_driver
// Four-digit multiplexed seven-segment driver with blinking and a colon.
// ----------------------------------------------------------------------------
// Takes one item per clock. Every item updates the display state in the cycle
// it is accepted; a digit tick puts its digit and segments into the output
// register, visible the cycle after. The input stalls only while that register
// holds a result not yet taken. Loads, colon flash and colon hold give no
// output. The configuration port is always ready and is meant to be written
// while no item is in flight.
module seven_segment_mux_blink_driver
  import ssmbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  blink_e      blink_sel_q, blink_sel_d;
  logic        zero_sup_q, zero_sup_d;
  logic [15:0] period_q, period_d;
  logic [15:0] blank_pt_q, blank_pt_d;
  logic [7:0]  colon_ticks_q, colon_ticks_d;

  logic [1:0]  digit_position_q, digit_position_d;
  logic [3:0]  bcd_q [NumDigits];
  logic [3:0]  bcd_d [NumDigits];
  logic [7:0]  pat_q [NumDigits];
  logic [7:0]  pat_d [NumDigits];
  logic [15:0] blink_counter_q, blink_counter_d;
  logic [2:0]  flags_q, flags_d;
  logic [8:0]  colon_count_q, colon_count_d;

  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        in_accept;
  logic [16:0] cnt_inc;
  logic [7:0]  bcd_lo, bcd_hi;
  logic [3:0]  gmask, bmask;
  logic [7:0]  seg;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cnt_inc = {1'b0, blink_counter_q} + 17'd1;
  assign bcd_lo  = to_bcd(in_data_i.low_value);
  assign bcd_hi  = to_bcd(in_data_i.high_value);
  assign gmask   = group_mask(blink_sel_q);

  always_comb begin
    blink_sel_d      = blink_sel_q;
    zero_sup_d       = zero_sup_q;
    period_d         = period_q;
    blank_pt_d       = blank_pt_q;
    colon_ticks_d    = colon_ticks_q;
    digit_position_d = digit_position_q;
    bcd_d            = bcd_q;
    pat_d            = pat_q;
    blink_counter_d  = blink_counter_q;
    flags_d          = flags_q;
    colon_count_d    = colon_count_q;
    out_d            = out_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    bmask            = 4'b0000;
    seg              = SegBlank;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BLINK_SELECT: begin
          blink_sel_d = blink_e'(cfg_data_i[1:0]);
          // selecting a mode brings back anything left dark
          if (flags_q != 3'b000) begin
            for (int i = 0; i < NumDigits; i++) begin
              pat_d[i] = digit_glyph(bcd_q[i], i == NumDigits - 1, zero_sup_q);
            end
            flags_d = 3'b000;
          end
        end
        CFG_ZERO_SUPPRESS: zero_sup_d    = cfg_data_i[0];
        CFG_BLINK_PERIOD:  period_d      = cfg_data_i;
        CFG_BLANK_POINT:   blank_pt_d    = cfg_data_i;
        CFG_COLON_TICKS:   colon_ticks_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    if (in_accept) begin
      case (in_data_i.operation)
        OP_LOAD: begin
          bcd_d[0] = bcd_lo[3:0];
          bcd_d[1] = bcd_lo[7:4];
          bcd_d[2] = bcd_hi[3:0];
          bcd_d[3] = in_data_i.minus_sign ? BcdMinus : bcd_hi[7:4];
          bmask = (flags_q[0] ? 4'b1111 : 4'b0000) | (flags_q[1] ? 4'b0011 : 4'b0000)
                | (flags_q[2] ? 4'b1100 : 4'b0000);
          for (int i = 0; i < NumDigits; i++) begin
            pat_d[i] = bmask[i] ? SegBlank
                                : digit_glyph(bcd_d[i], i == NumDigits - 1, zero_sup_q);
          end
        end
        OP_FLASH: colon_count_d = {1'b0, colon_ticks_q};
        OP_HOLD:  colon_count_d = ColonHold;
        default: begin
          digit_position_d = digit_position_q + 2'd1;
          blink_counter_d  = cnt_inc[15:0];
          // wrap shows the selected group, then the blank point may hide it again
          if (cnt_inc >= {1'b0, period_q}) begin
            blink_counter_d = 16'd0;
            for (int i = 0; i < NumDigits; i++) begin
              if (gmask[i]) pat_d[i] = digit_glyph(bcd_q[i], i == NumDigits - 1, zero_sup_q);
            end
            flags_d = flags_d & ~flag_mask(blink_sel_q);
          end
          if (blink_counter_d == blank_pt_q) begin
            for (int i = 0; i < NumDigits; i++) begin
              if (gmask[i]) pat_d[i] = SegBlank;
            end
            flags_d = flags_d | flag_mask(blink_sel_q);
          end
          seg = pat_d[digit_position_d];
          if (colon_count_q != 9'd0) begin
            seg = seg | ColonBit;
            if (!colon_count_q[8]) colon_count_d = colon_count_q - 9'd1;
          end
          out_d.digit_select = digit_position_d;
          out_d.segments     = seg;
          out_valid_d        = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_sel_q      <= BLINK_NONE;
      zero_sup_q       <= 1'b0;
      period_q         <= BlinkPeriodRst;
      blank_pt_q       <= BlankPointRst;
      colon_ticks_q    <= ColonTicksRst;
      digit_position_q <= 2'd0;
      blink_counter_q  <= 16'd0;
      flags_q          <= 3'b000;
      colon_count_q    <= 9'd0;
      out_valid_q      <= 1'b0;
      for (int i = 0; i < NumDigits; i++) begin
        bcd_q[i] <= 4'd0;
        pat_q[i] <= SegBlank;
      end
    end else begin
      blink_sel_q      <= blink_sel_d;
      zero_sup_q       <= zero_sup_d;
      period_q         <= period_d;
      blank_pt_q       <= blank_pt_d;
      colon_ticks_q    <= colon_ticks_d;
      digit_position_q <= digit_position_d;
      blink_counter_q  <= blink_counter_d;
      flags_q          <= flags_d;
      colon_count_q    <= colon_count_d;
      out_valid_q      <= out_valid_d;
      bcd_q            <= bcd_d;
      pat_q            <= pat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.operation == OP_TICK)
      |=> (digit_position_q == $past(digit_position_q) + 2'd1))
    else $error("digit position did not advance on a tick");

  a_tick_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.operation == OP_TICK)
      |=> (out_valid_o && out_data_o.digit_select == digit_position_q))
    else $error("tick result missing or on the wrong digit");

  a_hold_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (colon_count_q[8] && !(in_accept && in_data_i.operation == OP_FLASH))
      |=> colon_count_q[8])
    else $error("colon hold dropped without a flash");
`endif

endmodule

// File: tb/seven_segment_mux_blink_driver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seven_segment_mux_blink_driver_tb
// Self-checking bench for the multiplexed seven-segment driver. A driver sends
// queued items and the bench's own display model predicts every tick's digit
// and segments. A monitor compares each result as it is taken. Phases switch
// blink, suppression and colon settings while the block is idle.
// ----------------------------------------------------------------------------
module seven_segment_mux_blink_driver_tb;
  import ssmbd_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 75;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  seven_segment_mux_blink_driver DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // display model state
  blink_e      sel_r         = BLINK_NONE;
  logic        zs_r          = 1'b0;
  logic [15:0] period_r      = BlinkPeriodRst;
  logic [15:0] blank_pt_r    = BlankPointRst;
  logic [7:0]  colon_ticks_r = ColonTicksRst;
  logic [1:0]  pos_r         = '0;
  logic [3:0]  bcd_r [4]     = '{default: '0};
  logic [7:0]  pat_r [4]     = '{default: '0};
  logic [15:0] cnt_r         = '0;
  logic [2:0]  flags_r       = '0;
  logic [8:0]  colon_r       = '0;

  in_item_t    pending_items_q [$];
  out_item_t   expected_digits_q [$];

  int unsigned n_offered   = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_results   = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_fail      = 0;
  int unsigned tx_gap      = 0;
  int unsigned rx_wait     = 0;
  int unsigned rx_seen     = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_count = 0;
  logic        tx_idle_on  = 1'b0;
  logic        rx_idle_on  = 1'b0;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;

  function automatic logic [7:0] glyph(logic [3:0] code);
    logic [7:0] g;
    case (code)
      4'd0:    g = 8'b0011_1111;
      4'd1:    g = 8'b0000_0110;
      4'd2:    g = 8'b0101_1011;
      4'd3:    g = 8'b0100_1111;
      4'd4:    g = 8'b0110_0110;
      4'd5:    g = 8'b0110_1101;
      4'd6:    g = 8'b0111_1101;
      4'd7:    g = 8'b0000_0111;
      4'd8:    g = 8'b0111_1111;
      4'd9:    g = 8'b0110_1111;
      4'd10:   g = 8'b0100_0000;
      4'd11:   g = 8'b0111_1001;
      4'd12:   g = 8'b0111_0110;
      4'd13:   g = 8'b0011_1000;
      4'd14:   g = 8'b0111_0011;
      default: g = SegBlank;
    endcase
    return g;
  endfunction

  task automatic light_low();
    pat_r[0] = glyph(bcd_r[0]);
    pat_r[1] = glyph(bcd_r[1]);
  endtask

  task automatic light_high();
    pat_r[2] = glyph(bcd_r[2]);
    pat_r[3] = (zs_r && bcd_r[3] == 4'd0) ? SegBlank : glyph(bcd_r[3]);
  endtask

  task automatic dark_low();
    pat_r[0] = SegBlank;
    pat_r[1] = SegBlank;
  endtask

  task automatic dark_high();
    pat_r[2] = SegBlank;
    pat_r[3] = SegBlank;
  endtask

  task automatic apply_register(cfg_e idx, logic [CfgDataW-1:0] d);
    case (idx)
      CFG_BLINK_SELECT: begin
        sel_r = blink_e'(d[1:0]);
        // any select write restores blanked digits
        if (flags_r != 3'b000) begin
          light_low();
          light_high();
          flags_r = 3'b000;
        end
      end
      CFG_ZERO_SUPPRESS: zs_r = d[0];
      CFG_BLINK_PERIOD:  period_r = d;
      CFG_BLANK_POINT:   blank_pt_r = d;
      CFG_COLON_TICKS:   colon_ticks_r = d[7:0];
      default: ;
    endcase
  endtask

  task automatic advance_display(input in_item_t it, output logic has_digit,
                                 output out_item_t digit);
    int unsigned hv;
    int unsigned lv;
    logic [16:0] c;
    logic [7:0]  seg;
    has_digit = 1'b0;
    digit = '0;
    case (it.operation)
      OP_LOAD: begin
        lv = (it.low_value > 7'd99) ? 99 : int'(it.low_value);
        hv = (it.high_value > 7'd99) ? 99 : int'(it.high_value);
        bcd_r[0] = 4'(lv % 10);
        bcd_r[1] = 4'(lv / 10);
        bcd_r[2] = 4'(hv % 10);
        bcd_r[3] = it.minus_sign ? BcdMinus : 4'(hv / 10);
        light_low();
        light_high();
        if (flags_r[0]) begin
          dark_low();
          dark_high();
        end
        if (flags_r[1]) dark_low();
        if (flags_r[2]) dark_high();
      end
      OP_FLASH: colon_r = {1'b0, colon_ticks_r};
      OP_HOLD:  colon_r = ColonHold;
      default: begin
        pos_r = pos_r + 2'd1;
        c = {1'b0, cnt_r} + 17'd1;
        if (c >= {1'b0, period_r}) begin
          c = '0;
          case (sel_r)
            BLINK_ALL: begin
              light_low();
              light_high();
              flags_r[0] = 1'b0;
            end
            BLINK_HIGH: begin
              light_high();
              flags_r[2] = 1'b0;
            end
            BLINK_LOW: begin
              light_low();
              flags_r[1] = 1'b0;
            end
            default: ;
          endcase
        end
        cnt_r = c[15:0];
        // blank check comes after the wrap, so a zero point blanks at once
        if (cnt_r == blank_pt_r) begin
          case (sel_r)
            BLINK_ALL: begin
              dark_low();
              dark_high();
              flags_r[0] = 1'b1;
            end
            BLINK_HIGH: begin
              dark_high();
              flags_r[2] = 1'b1;
            end
            BLINK_LOW: begin
              dark_low();
              flags_r[1] = 1'b1;
            end
            default: ;
          endcase
        end
        seg = pat_r[pos_r];
        if (colon_r != 9'd0) begin
          seg = seg | ColonBit;
          if (!colon_r[8]) colon_r = colon_r - 9'd1;
        end
        digit.digit_select = pos_r;
        digit.segments = seg;
        has_digit = 1'b1;
      end
    endcase
  endtask

  function automatic in_item_t mk_item(op_e op, int unsigned hi, int unsigned lo, bit minus);
    in_item_t it;
    it.operation = op;
    it.high_value = 7'(hi);
    it.low_value = 7'(lo);
    it.minus_sign = minus;
    return it;
  endfunction

  function automatic logic [6:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return 7'($urandom_range(0, 9));
    if (r == 9) return 7'($urandom_range(100, 127));
    return 7'($urandom_range(0, 99));
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) it.operation = OP_TICK;
    else if (r < 82) it.operation = OP_LOAD;
    else if (r < 91) it.operation = OP_FLASH;
    else it.operation = OP_HOLD;
    it.high_value = pick_value();
    it.low_value = pick_value();
    it.minus_sign = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  task automatic write_reg(cfg_e idx, logic [CfgDataW-1:0] d);
    int unsigned seen;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    seen = n_cfg;
    do @(negedge clk_i); while (n_cfg == seen);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup_display(blink_e sel, logic zs, logic [15:0] period,
                               logic [15:0] blank_pt, logic [7:0] colon);
    bit sel_first;
    sel_first = $urandom_range(0, 1);
    if (sel_first) write_reg(CFG_BLINK_SELECT, CfgDataW'(sel));
    write_reg(CFG_ZERO_SUPPRESS, CfgDataW'(zs));
    write_reg(CFG_BLINK_PERIOD, period);
    write_reg(CFG_BLANK_POINT, blank_pt);
    write_reg(CFG_COLON_TICKS, CfgDataW'(colon));
    if (!sel_first) write_reg(CFG_BLINK_SELECT, CfgDataW'(sel));
  endtask

  // the block also settles on loads and colon items that give no result
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_items_q.size() != 0 || n_accepted != n_offered ||
           expected_digits_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  // item driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || n_accepted == n_offered) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items_q.size() != 0) begin
          in_data_i  <= pending_items_q.pop_front();
          in_valid_i <= 1'b1;
          n_offered++;
          tx_gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (n_results != rx_seen) begin
        rx_seen = n_results;
        rx_wait = rx_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: checks results, then tracks register writes and accepted items
  always @(posedge clk_i) begin
    out_item_t want;
    logic      has_digit;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_digits_q.size() == 0) begin
          $error("unexpected result: digit_select %0d segments 0x%02h",
                 out_data_o.digit_select, out_data_o.segments);
          n_fail++;
        end else begin
          want = expected_digits_q.pop_front();
          if (out_data_o.digit_select !== want.digit_select) begin
            $error("digit_select mismatch: expected %0d, actual %0d",
                   want.digit_select, out_data_o.digit_select);
            n_fail++;
          end
          if (out_data_o.segments !== want.segments) begin
            $error("segments mismatch: expected 0x%02h, actual 0x%02h",
                   want.segments, out_data_o.segments);
            n_fail++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        n_cfg++;
        apply_register(cfg_e'(cfg_index_i), cfg_data_i);
      end
      if (in_valid_i && in_ready_o) begin
        n_accepted++;
        advance_display(in_data_i, has_digit, want);
        if (has_digit) expected_digits_q.push_back(want);
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    int unsigned p;
    int unsigned k;
    logic [15:0] period;
    logic [15:0] blank_pt;
    logic [7:0]  colon;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: blank digits before any load, no blinking
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    pending_items_q.push_back(mk_item(OP_LOAD, 12, 34, 0));
    pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    wait_idle();

    // fast blink on all digits, suppression on, short colon
    setup_display(BLINK_ALL, 1'b1, 16'd3, 16'd1, 8'd2);
    pending_items_q.push_back(mk_item(OP_LOAD, 7, 0, 0));
    repeat (3) pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    pending_items_q.push_back(mk_item(OP_FLASH, 0, 0, 0));
    repeat (3) pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    // saturation with the minus sign while blank flags are active
    pending_items_q.push_back(mk_item(OP_LOAD, 127, 100, 1));
    repeat (2) pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    pending_items_q.push_back(mk_item(OP_HOLD, 0, 0, 0));
    repeat (2) pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    pending_items_q.push_back(mk_item(OP_LOAD, 99, 99, 0));
    repeat (2) pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    pending_items_q.push_back(mk_item(OP_LOAD, 64, 0, 1));
    pending_items_q.push_back(mk_item(OP_TICK, 0, 0, 0));
    wait_idle();

    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: setup_display(BLINK_ALL, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF);
        1: setup_display(BLINK_HIGH, 1'b1, 16'd0, 16'd0, 8'd0);
        2: setup_display(BLINK_LOW, 1'b1, 16'd1, 16'd1, 8'd5);
        3: setup_display(BLINK_NONE, 1'b0, 16'd2, 16'd0, 8'd1);
        default: begin
          period = 16'($urandom_range(1, 24));
          if ($urandom_range(0, 4) == 0) blank_pt = period + 16'd5;
          else blank_pt = 16'($urandom_range(0, period));
          colon = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 12));
          setup_display(blink_e'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        period, blank_pt, colon);
        end
      endcase
      if (p % 4 == 0) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = 1'($urandom_range(0, 1));
        rx_idle_on = 1'($urandom_range(0, 1));
      end
      // sender keeps offering while the receiver sits out a long stretch
      if (p == 5) begin
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
      end
      for (k = 0; k < PhaseItems; k++) pending_items_q.push_back(rand_item());
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (n_fail == 0 && expected_digits_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ssmbd_pkg.sv
hdl/seven_segment_mux_blink_driver.sv
tb/seven_segment_mux_blink_driver_tb.sv
